// ===== design/tccs_pkg.sv =====
// Shared types, constants and helpers for the text console engine.
package tccs_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;
  localparam int TAB_STOPS  = COLUMNS / TAB_WIDTH + 1;

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CX_W   = $clog2(COLUMNS + TAB_WIDTH + 1);
  localparam int RX_W   = ROW_W + 1;

  localparam logic [7:0] ATTR_RESET = 8'h0F;
  localparam logic [7:0] CODE_BS    = 8'h08;
  localparam logic [7:0] CODE_TAB   = 8'h09;
  localparam logic [7:0] CODE_LF    = 8'h0A;
  localparam logic [7:0] CODE_CR    = 8'h0D;
  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_DEL   = 8'h7F;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } tccs_in_t;

  typedef struct packed {
    logic [15:0] cell_word;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_addr;
  } tccs_out_t;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef enum logic [2:0] {
    CH_BS,
    CH_TAB,
    CH_CR,
    CH_LF,
    CH_PRINT,
    CH_IGNORE
  } chr_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    chr_kind_t         chr;
    logic [7:0]        char_code;
    logic              idx_ok;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_FILL,
    BK_IDLE,
    BK_READ,
    BK_SCROLL
  } bk_state_t;

  function automatic logic [ADDR_W-1:0] loc_of(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
    loc_of = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  // next tab stop strictly above col
  function automatic logic [CX_W-1:0] tab_stop(input logic [COL_W-1:0] col);
    logic [CX_W-1:0] r;
    r = '0;
    for (int k = TAB_STOPS; k >= 1; k--) begin
      if (k * TAB_WIDTH > int'(col)) r = CX_W'(k * TAB_WIDTH);
    end
    tab_stop = r;
  endfunction

endpackage

// ===== design/tccs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== design/tccs_front.sv =====
// Front end: decodes incoming transactions and queues them for the back end.
module tccs_front import tccs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  tccs_in_t item,
  input  logic     pop,
  output logic     full,
  output logic     empty,
  output cmd_t     head
);
  cmd_t       q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;

  always_comb begin
    dec.char_code = item.char_code;
    dec.idx_ok    = (int'(item.cell_index) < CELL_COUNT);
    dec.addr      = ADDR_W'(item.cell_index);
    case (item.opcode)
      OP_PUT:   dec.kind = CMD_PUT;
      OP_CLEAR: dec.kind = CMD_CLEAR;
      OP_READ:  dec.kind = CMD_READ;
      default:  dec.kind = CMD_NOP;
    endcase
    case (item.char_code)
      CODE_BS:  dec.chr = CH_BS;
      CODE_TAB: dec.chr = CH_TAB;
      CODE_CR:  dec.chr = CH_CR;
      CODE_LF:  dec.chr = CH_LF;
      default: begin
        if (item.char_code >= CODE_SPACE && item.char_code <= CODE_DEL) dec.chr = CH_PRINT;
        else dec.chr = CH_IGNORE;
      end
    endcase
  end

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) q_r[wp_r] <= dec;
  end

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = q_r[rp_r];
endmodule

// ===== design/tccs_back.sv =====
// Back end: executes queued commands against the screen store and cursor.
module tccs_back import tccs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] attr,
  input  logic       empty,
  input  cmd_t       head,
  output logic       pop,
  output logic       init_busy,
  output logic       out_strobe,
  output tccs_out_t  out_item
);
  bk_state_t         state_r, state_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [15:0]       fill_r, fill_nxt;
  logic              init_r, init_nxt;
  logic              rdok_r, rdok_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic              ov_r, ov_nxt;
  tccs_out_t         out_r, out_nxt;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata, rdata, word;
  logic [CX_W-1:0]   cx;
  logic [RX_W-1:0]   rx;
  logic              scroll;
  logic [15:0]       blank;
  logic [ADDR_W-1:0] loc;

  tccs_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign blank = {attr, CODE_SPACE};

  // put-char cursor arithmetic
  always_comb begin
    cx = CX_W'(col_r);
    rx = RX_W'(row_r);
    case (head.chr)
      CH_BS:    if (col_r != '0) cx = CX_W'(col_r) - CX_W'(1);
      CH_TAB:   cx = tab_stop(col_r);
      CH_CR:    cx = '0;
      CH_LF: begin
        cx = '0;
        rx = RX_W'(row_r) + RX_W'(1);
      end
      CH_PRINT: cx = CX_W'(col_r) + CX_W'(1);
      default:  cx = CX_W'(col_r);
    endcase
    if (int'(cx) >= COLUMNS) begin
      cx = '0;
      rx = rx + RX_W'(1);
    end
    scroll = (int'(rx) >= ROWS);
    if (scroll) rx = RX_W'(ROWS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_FILL;
      k_r     <= '0;
      fill_r  <= '0;
      init_r  <= 1'b1;
      col_r   <= '0;
      row_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      fill_r  <= fill_nxt;
      init_r  <= init_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ov_r    <= ov_nxt;
    end
    rdok_r <= rdok_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    fill_nxt  = fill_r;
    init_nxt  = init_r;
    rdok_nxt  = rdok_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ov_nxt    = 1'b0;
    word      = '0;
    pop       = 1'b0;
    we        = 1'b0;
    waddr     = k_r;
    wdata     = fill_r;
    re        = 1'b0;
    raddr     = head.addr;
    case (state_r)
      BK_FILL: begin
        we = 1'b1;
        k_nxt = k_r + ADDR_W'(1);
        if (int'(k_r) == CELL_COUNT - 1) begin
          state_nxt = BK_IDLE;
          init_nxt  = 1'b0;
          ov_nxt    = !init_r;
        end
      end
      BK_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          case (head.kind)
            CMD_PUT: begin
              we      = (head.chr == CH_PRINT);
              waddr   = loc_of(row_r, col_r);
              wdata   = {attr, head.char_code};
              col_nxt = COL_W'(cx);
              row_nxt = ROW_W'(rx);
              if (scroll) begin
                state_nxt = BK_SCROLL;
                k_nxt     = '0;
              end else ov_nxt = 1'b1;
            end
            CMD_CLEAR: begin
              state_nxt = BK_FILL;
              k_nxt     = '0;
              fill_nxt  = blank;
              col_nxt   = '0;
              row_nxt   = '0;
            end
            CMD_READ: begin
              re        = head.idx_ok;
              rdok_nxt  = head.idx_ok;
              state_nxt = BK_READ;
            end
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      BK_READ: begin
        word      = rdok_r ? rdata : '0;
        ov_nxt    = 1'b1;
        state_nxt = BK_IDLE;
      end
      BK_SCROLL: begin
        // read row below at k, write cell k-1 with last read data
        re    = (int'(k_r) < MOVE_COUNT);
        raddr = ADDR_W'(int'(k_r) + COLUMNS);
        we    = (k_r != '0);
        waddr = k_r - ADDR_W'(1);
        wdata = rdata;
        k_nxt = k_r + ADDR_W'(1);
        if (int'(k_r) == MOVE_COUNT) begin
          state_nxt = BK_FILL;
          k_nxt     = ADDR_W'(MOVE_COUNT);
          fill_nxt  = blank;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    loc                   = loc_of(row_nxt, col_nxt);
    out_nxt.cell_word     = word;
    out_nxt.cursor_column = 7'(col_nxt);
    out_nxt.cursor_row    = 5'(row_nxt);
    out_nxt.cursor_addr   = 11'(loc);
  end

  assign init_busy  = init_r;
  assign out_strobe = ov_r;
  assign out_item   = out_r;

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(col_r) < COLUMNS) && (int'(row_r) < ROWS))
    else $error("cursor out of range");
  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !ov_r)
    else $error("result during initial clear");
  a_scroll_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCROLL) |-> (int'(k_r) <= MOVE_COUNT))
    else $error("scroll counter overrun");
endmodule

// ===== design/text_console_cursor_scroll.sv =====
// Top level of the text console engine: front end, back end and attribute register.
//
//  channel  ports                     handshake
//  input    start, busy, in_item      taken when start && !busy
//  result   out_strobe, out_item      one cycle per result, no backpressure
//  config   cfg_we, cfg_wdata         written when cfg_we
//
// A put-char or unused opcode completes from idle and a read via a read state. Clear
// writes every cell; a scrolling put-char moves rows up and blanks the last row, both
// set by the single write port of the screen RAM. After reset the screen RAM is swept
// to zero with busy high. A two-entry queue lets start be taken while the back end
// works; busy rises when it is full.
module text_console_cursor_scroll import tccs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  tccs_in_t   in_item,
  output logic       out_strobe,
  output tccs_out_t  out_item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  logic [7:0] attr_r;
  logic       full, empty, pop, init_busy;
  cmd_t       head;

  always_ff @(posedge clk) begin
    if (!rst_n) attr_r <= ATTR_RESET;
    else if (cfg_we) attr_r <= cfg_wdata;
  end

  assign busy = full | init_busy;

  tccs_front u_front (
    .clk(clk), .rst_n(rst_n), .push(start & ~busy), .item(in_item),
    .pop(pop), .full(full), .empty(empty), .head(head)
  );

  tccs_back u_back (
    .clk(clk), .rst_n(rst_n), .attr(attr_r), .empty(empty), .head(head),
    .pop(pop), .init_busy(init_busy), .out_strobe(out_strobe), .out_item(out_item)
  );
endmodule
